// ----- rtl/packed_pixel_line_stretch_defines.svh -----
// assertion macros shared by the line stretch rtl
`ifndef PACKED_PIXEL_LINE_STRETCH_DEFINES_SVH
`define PACKED_PIXEL_LINE_STRETCH_DEFINES_SVH

`ifndef SYNTHESIS
`define PPLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppls assertion failed");
`define PPLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppls assertion failed");
`else
`define PPLS_ASSERT_IMP(lbl, ante, cons)
`define PPLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ppls_pkg.sv -----
// shared constants and types of the line stretch
package ppls_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RESULTS = 62;
  localparam int MAX_RATIO   = 31;
  localparam int PH_W        = $clog2(MAX_WIDTH);
  localparam int CNT_W       = PH_W + 1;
  localparam int CFG_W       = 11;
  localparam int WT_W        = 8;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PH_W-1:0]  phase_t;
  typedef logic [WT_W-1:0]  wt_t;

  typedef struct packed {
    logic done;
    wt_t  quot;
  } div_res_t;

endpackage

// ----- rtl/packed_pixel_line_stretch.sv -----
// line stretch top level: config registers, sequencer, blend and output register
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | in_tdata = src_pixel[31:0]
//  out     | out | out_tvalid/out_tready | out_tdata = out_pixel[31:0], out_tlast = line_end
//  cfg     | in  | apb, pready tied high | 0x0 dest_width, 0x4 source_width, 0x8 pixel_mode
//
//  the first pixel of a line gives no beat
//  every later pixel gives result beats in turn: for each, the divider finds the weight
//  bit by bit, ST_DIV takes it, ST_MULA and ST_MULB multiply, and ST_MULB waits while
//  the output register stays full; the input is free again once the last beat of a pixel
//  sits in the output register
//  rst_n is synchronous; registers return to 640 / 512 / xrgb, counters to zero
`include "packed_pixel_line_stretch_defines.svh"

module packed_pixel_line_stretch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // src_pixel[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_pixel[31:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W = ppls_pkg::CNT_W;
  localparam int PH_W  = ppls_pkg::PH_W;
  localparam int CFG_W = ppls_pkg::CFG_W;
  localparam int K_W   = ppls_pkg::K_W;
  localparam int EXT_W = 18;

  localparam logic [1:0] REG_DEST = 2'd0;
  localparam logic [1:0] REG_SRC  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MULA = 3'd2;
  localparam logic [2:0] ST_MULB = 3'd3;

  logic [CFG_W-1:0] dest_r;
  logic [CFG_W-1:0] src_r;
  logic             mode_r;

  logic [2:0]        state_r;
  ppls_pkg::cnt_t    in_cnt_r;
  ppls_pkg::cnt_t    out_cnt_r;
  ppls_pkg::phase_t  phase_r;
  ppls_pkg::cnt_t    s_r;
  ppls_pkg::cnt_t    d_r;
  logic [K_W-1:0]    k_r;
  logic              last_r;
  logic [31:0]       left_r;
  logic [31:0]       right_r;
  ppls_pkg::wt_t     w_r;
  logic [31:0]       acc_lo_r;
  logic [23:0]       acc_hi_r;
  logic              out_valid_r;
  logic [31:0]       out_pixel_r;
  logic              out_last_r;

  // config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= CFG_W'(640);
      src_r  <= CFG_W'(512);
      mode_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_DEST: dest_r <= cfg_pwdata[CFG_W-1:0];
        REG_SRC:  src_r  <= cfg_pwdata[CFG_W-1:0];
        REG_MODE: mode_r <= cfg_pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_DEST: cfg_prdata = 32'(dest_r);
      REG_SRC:  cfg_prdata = 32'(src_r);
      REG_MODE: cfg_prdata = 32'(mode_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // width clamps
  logic [EXT_W-1:0] s_ext;
  logic [EXT_W-1:0] hi_ext;
  logic [EXT_W-1:0] d_ext;
  ppls_pkg::cnt_t   eff_s;
  ppls_pkg::cnt_t   eff_d;

  always_comb begin
    s_ext = EXT_W'(src_r);
    if (s_ext < EXT_W'(2)) begin
      s_ext = EXT_W'(2);
    end else if (s_ext > EXT_W'(ppls_pkg::MAX_WIDTH)) begin
      s_ext = EXT_W'(ppls_pkg::MAX_WIDTH);
    end
    hi_ext = EXT_W'(s_ext * EXT_W'(ppls_pkg::MAX_RATIO));
    if (hi_ext > EXT_W'(ppls_pkg::MAX_WIDTH)) begin
      hi_ext = EXT_W'(ppls_pkg::MAX_WIDTH);
    end
    d_ext = EXT_W'(dest_r);
    if (d_ext > hi_ext) begin
      d_ext = hi_ext;
    end
    if (d_ext < s_ext) begin
      d_ext = s_ext;
    end
    eff_s = CNT_W'(s_ext);
    eff_d = CNT_W'(d_ext);
  end

  // line restart check and input beat
  logic           in_acc;
  logic           restart;
  ppls_pkg::cnt_t ic;
  ppls_pkg::cnt_t oc;
  ppls_pkg::phase_t ph;
  logic [31:0]    pix;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    restart = (in_cnt_r >= eff_s) || (out_cnt_r >= eff_d) || (CNT_W'(phase_r) >= eff_d);
    ic      = restart ? '0 : in_cnt_r;
    oc      = restart ? '0 : out_cnt_r;
    ph      = restart ? '0 : phase_r;
    pix     = mode_r ? in_tdata : {16'h0000, in_tdata[15:0]};
  end

  // blend datapath
  logic [31:0] m_mask;
  logic [31:0] n_mask;
  logic [8:0]  r_full;
  logic [8:0]  p_w;
  logic [8:0]  q_w;
  logic [23:0] a_m;
  logic [15:0] a_n;
  logic [23:0] b_m;
  logic [15:0] b_n;
  logic [31:0] lo_sum;
  logic [23:0] hi_sum;
  logic [31:0] lo_sh;
  logic [23:0] hi_sh;
  logic [31:0] blend_px;

  always_comb begin
    m_mask   = mode_r ? 32'h00ff00ff : 32'h0000f81f;
    n_mask   = mode_r ? 32'h0000ff00 : 32'h000007e0;
    r_full   = mode_r ? 9'd256 : 9'd32;
    q_w      = {1'b0, w_r};
    p_w      = r_full - q_w;
    a_m      = 24'(left_r & m_mask);
    a_n      = 16'(left_r & n_mask);
    b_m      = 24'(right_r & m_mask);
    b_n      = 16'(right_r & n_mask);
    lo_sum   = acc_lo_r + (32'(b_m) * 32'(q_w));
    hi_sum   = acc_hi_r + (24'(b_n) * 24'(q_w));
    lo_sh    = mode_r ? (lo_sum >> 8) : (lo_sum >> 5);
    hi_sh    = mode_r ? (hi_sum >> 8) : (hi_sum >> 5);
    blend_px = (lo_sh & m_mask) | (32'(hi_sh) & n_mask);
  end

  // per-beat counter step
  ppls_pkg::cnt_t   oc1;
  logic [K_W-1:0]   k1;
  ppls_pkg::cnt_t   psum;
  logic             wrap;
  ppls_pkg::phase_t ph_step;
  logic             cont;
  logic             out_acc;
  logic             out_load;

  always_comb begin
    oc1      = out_cnt_r + 1'b1;
    k1       = k_r + 1'b1;
    psum     = CNT_W'(phase_r) + s_r;
    wrap     = (psum >= d_r);
    ph_step  = wrap ? PH_W'(psum - d_r) : PH_W'(psum);
    cont     = (oc1 < d_r) && (k1 < K_W'(ppls_pkg::MAX_RESULTS)) && (!wrap || last_r);
    out_acc  = out_valid_r && out_tready;
    out_load = (state_r == ST_MULB) && (!out_valid_r || out_tready);
  end

  // weight divider
  logic               div_start;
  ppls_pkg::phase_t   div_phase;
  ppls_pkg::cnt_t     div_dest;
  ppls_pkg::div_res_t div_res;

  always_comb begin
    div_start = (in_acc && (ic != '0)) || (out_load && cont);
    div_phase = (state_r == ST_IDLE) ? phase_r : ph_step;
    div_dest  = (state_r == ST_IDLE) ? eff_d : d_r;
  end

  ppls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .phase (div_phase),
    .dest  (div_dest),
    .res   (div_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      phase_r     <= '0;
      k_r         <= '0;
      left_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            out_cnt_r <= oc;
            phase_r   <= ph;
            if (ic == '0) begin
              left_r   <= pix;
              in_cnt_r <= CNT_W'(1);
            end else begin
              right_r <= pix;
              last_r  <= (ic == eff_s - 1'b1);
              s_r     <= eff_s;
              d_r     <= eff_d;
              k_r     <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            w_r     <= mode_r ? div_res.quot : (div_res.quot >> 3);
            state_r <= ST_MULA;
          end
        end
        ST_MULA: begin
          acc_lo_r <= 32'(a_m) * 32'(p_w);
          acc_hi_r <= 24'(a_n) * 24'(p_w);
          state_r  <= ST_MULB;
        end
        ST_MULB: begin
          if (out_load) begin
            k_r <= k1;
            if (wrap) begin
              left_r <= right_r;
            end
            if (cont) begin
              out_cnt_r <= oc1;
              phase_r   <= ph_step;
              state_r   <= ST_DIV;
            end else begin
              state_r <= ST_IDLE;
              if (last_r) begin
                in_cnt_r  <= '0;
                out_cnt_r <= '0;
                phase_r   <= '0;
              end else begin
                in_cnt_r  <= in_cnt_r + 1'b1;
                out_cnt_r <= oc1;
                phase_r   <= ph_step;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= blend_px;
      out_last_r  <= (oc1 == d_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

  `PPLS_ASSERT_IMP(a_div_phase_in_range, state_r == ST_DIV, CNT_W'(phase_r) < d_r)
  `PPLS_ASSERT_NEXT(a_item_end_frees_input, out_load && !cont, in_tready)
  `PPLS_ASSERT_IMP(a_result_cap, state_r != ST_IDLE, k_r < K_W'(ppls_pkg::MAX_RESULTS))
  `PPLS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(out_tdata))

endmodule

// ----- rtl/ppls_div.sv -----
// bit-serial weight divider: floor(phase * 256 / dest), one quotient bit per cycle
`include "packed_pixel_line_stretch_defines.svh"

module ppls_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ppls_pkg::phase_t      phase,
  input  ppls_pkg::cnt_t        dest,
  output ppls_pkg::div_res_t    res
);

  localparam int STEP_W = $clog2(ppls_pkg::WT_W);

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  ppls_pkg::phase_t       rem_r;
  ppls_pkg::wt_t          quot_r;

  logic [ppls_pkg::CNT_W-1:0] rem2;
  logic                       ge;
  ppls_pkg::phase_t           rem_nxt;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = (rem2 >= dest);
    rem_nxt = ge ? ppls_pkg::PH_W'(rem2 - dest) : ppls_pkg::PH_W'(rem2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ppls_pkg::WT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= phase;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[ppls_pkg::WT_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

  `PPLS_ASSERT_IMP(a_div_no_restart, start, !busy_r)
  `PPLS_ASSERT_IMP(a_div_rem_below_dest, busy_r, ppls_pkg::CNT_W'(rem_r) < dest)
  `PPLS_ASSERT_IMP(a_div_done_idle, done_r, !busy_r)

endmodule
